// ===== rtl/core/binary_max_heap_queue_core_macros.svh =====
// Assertion macros shared by the heap queue RTL.
// No dependencies.
`ifndef BINARY_MAX_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_CORE_MACROS_SVH
`define BMHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BMHQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Package for the binary max-heap queue core: widths, codes and states.
// No dependencies.
`default_nettype none
package bmhq_pkg;
  localparam int Depth = 1024;
  localparam int AddrW = 10;
  localparam int CntW = 11;
  localparam int KeyW = 32;
  localparam int PayW = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0, OP_POP = 3'd1, OP_PEEK = 3'd2, OP_REMOVE = 3'd3, OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_BAD = 2'd2, ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDTOP, S_TAKE, S_FILL, S_UPRD, S_UPCMP, S_DNRD, S_DNL, S_DNCMP,
    S_SRD, S_SCMP, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap queue: sequencer plus entry memory.
// Depends on bmhq_pkg and binary_max_heap_queue_core_macros.svh.
// Channel  | Ports                                          | Handshake
// input    | in_opcode in_key in_payload in_index           | start & !busy
// result   | out_status out_key out_payload out_found_index | out_valid, one cycle
//          | out_entry_count                                |
// config   | cfg_we cfg_data                                | cfg_we
// A transaction runs from the start cycle to the result strobe; insert sifts the entry up,
// and search compares the payload of each entry in turn from in_index upward.
// The entry memory has one write port and one registered read port.
// Reset clears the count and sets max_entries to 1024; the memory is not cleared.
// The receiver cannot stall; busy stays high until the result strobe.
`default_nettype none
`include "binary_max_heap_queue_core_macros.svh"
module binary_max_heap_queue_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              in_opcode,
  input  wire logic [31:0]             in_key,
  input  wire logic [31:0]             in_payload,
  input  wire logic [9:0]              in_index,
  input  wire logic                    cfg_we,
  input  wire logic [10:0]             cfg_data,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [31:0]                  out_key,
  output logic [31:0]                  out_payload,
  output logic [9:0]                   out_found_index,
  output logic [10:0]                  out_entry_count
);
  import bmhq_pkg::*;

  logic [KeyW+PayW-1:0] mem [Depth];
  logic [KeyW+PayW-1:0] rd_q;
  logic                 we;
  logic [AddrW-1:0]     wa, ra;
  logic [KeyW+PayW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt, maxe_r;
  logic [2:0] op_r, op_nxt;
  logic [PayW-1:0] pay_r, pay_nxt;
  logic [KeyW+PayW-1:0] cur_r, cur_nxt, lft_r, lft_nxt, res_r, res_nxt;
  logic [AddrW-1:0] pos_r, pos_nxt, idx_r, idx_nxt;
  logic [CntW-1:0] sc_r, sc_nxt;
  logic [1:0] st_r, st_nxt;
  logic ov_r, ov_nxt;

  logic [CntW-1:0] limit, lpos, rpos;
  logic [AddrW-1:0] up;
  logic [KeyW-1:0] ck, rk, lk;

  assign limit = (maxe_r > CntW'(Depth)) ? CntW'(Depth) : maxe_r;
  assign up    = AddrW'((pos_r - 1'b1) >> 1);
  assign lpos  = {pos_r, 1'b1};
  assign rpos  = {pos_r, 1'b0} + CntW'(2);
  assign ck    = cur_r[KeyW+PayW-1:PayW];
  assign rk    = rd_q[KeyW+PayW-1:PayW];
  assign lk    = lft_r[KeyW+PayW-1:PayW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      maxe_r  <= CntW'(Depth);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        maxe_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  pay_r <= pay_nxt; cur_r <= cur_nxt; lft_r <= lft_nxt;
    res_r <= res_nxt; pos_r <= pos_nxt; idx_r <= idx_nxt; sc_r <= sc_nxt;
    st_r <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; op_nxt = op_r; pay_nxt = pay_r;
    cur_nxt = cur_r; lft_nxt = lft_r; res_nxt = res_r; pos_nxt = pos_r;
    idx_nxt = idx_r; sc_nxt = sc_r; st_nxt = st_r; ov_nxt = 1'b0;
    we = 1'b0; wa = pos_r; wd = cur_r; ra = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_opcode; pay_nxt = in_payload; idx_nxt = in_index;
          res_nxt = '0; st_nxt = ST_BAD; pos_nxt = '0; state_nxt = S_DONE;
          unique case (in_opcode)
            OP_INSERT: begin
              if (cnt_r >= limit) begin
                st_nxt = ST_FULL;
              end else begin
                cur_nxt = {in_key, in_payload}; res_nxt = {in_key, in_payload};
                pos_nxt = AddrW'(cnt_r); cnt_nxt = cnt_r + 1'b1; st_nxt = ST_OK;
                state_nxt = (cnt_r == '0) ? S_FILL : S_UPRD;
              end
            end
            OP_POP, OP_PEEK: if (cnt_r != '0) begin
              idx_nxt = '0; state_nxt = S_RDTOP;
            end
            OP_REMOVE: if (CntW'(in_index) < cnt_r) state_nxt = S_RDTOP;
            OP_SEARCH: if (CntW'(in_index) < cnt_r) begin
              st_nxt = ST_NOTFOUND; sc_nxt = CntW'(in_index); state_nxt = S_SRD;
            end
            default: ;
          endcase
        end
      end
      S_RDTOP: begin
        ra = idx_r; state_nxt = S_TAKE;
      end
      S_TAKE: begin
        res_nxt = rd_q; st_nxt = ST_OK; pos_nxt = idx_r;
        if (op_r == OP_PEEK) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1; ra = AddrW'(cnt_r - 1'b1);
          state_nxt = (CntW'(idx_r) < cnt_r - 1'b1) ? S_FILL : S_DONE;
          if (state_nxt == S_FILL) pos_nxt = AddrW'(CntW'(Depth) - 1'b1);
        end
      end
      S_FILL: begin
        // Insert writes the new entry; remove/pop take the fetched last entry then choose direction.
        if (op_r == OP_INSERT) begin
          we = 1'b1; wa = pos_r; wd = cur_r; state_nxt = S_DONE;
        end else if (pos_r == AddrW'(CntW'(Depth) - 1'b1) && idx_r != pos_r) begin
          cur_nxt = rd_q; pos_nxt = idx_r; ra = AddrW'((idx_r - 1'b1) >> 1);
          state_nxt = (idx_r == '0) ? S_DNRD : S_UPCMP;
        end else begin
          cur_nxt = rd_q; pos_nxt = idx_r; ra = AddrW'((idx_r - 1'b1) >> 1);
          state_nxt = (idx_r == '0) ? S_DNRD : S_UPCMP;
        end
      end
      S_UPRD: begin
        ra = up; state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if (pos_r != '0 && rk < ck) begin
          we = 1'b1; wa = pos_r; wd = rd_q; pos_nxt = up;
          if (op_r != OP_INSERT) op_nxt = OP_INSERT;
          state_nxt = (up == '0) ? S_FILL : S_UPRD;
          if (up == '0) begin
            idx_nxt = '0;
          end
        end else if (op_r == OP_INSERT) begin
          we = 1'b1; wd = cur_r; state_nxt = S_DONE;
        end else begin
          state_nxt = S_DNRD;
        end
        if (op_r == OP_INSERT && we && wd == cur_r) res_nxt[0] = res_r[0];
      end
      S_DNRD: begin
        if (lpos < cnt_r) begin
          ra = AddrW'(lpos); state_nxt = S_DNL;
        end else begin
          we = 1'b1; state_nxt = S_DONE;
        end
      end
      S_DNL: begin
        lft_nxt = rd_q; ra = AddrW'(rpos);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (rpos < cnt_r && rk > ck && rk > lk) begin
          we = 1'b1; wd = rd_q; pos_nxt = AddrW'(rpos); state_nxt = S_DNRD;
        end else if (lk > ck) begin
          we = 1'b1; wd = lft_r; pos_nxt = AddrW'(lpos); state_nxt = S_DNRD;
        end else begin
          we = 1'b1; wd = cur_r; state_nxt = S_DONE;
        end
      end
      S_SRD: begin
        ra = AddrW'(sc_r); state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rd_q[PayW-1:0] == pay_r) begin
          st_nxt = ST_OK; res_nxt = rd_q; pos_nxt = AddrW'(sc_r); state_nxt = S_DONE;
        end else if (sc_r + 1'b1 >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          sc_nxt = sc_r + 1'b1; state_nxt = S_SRD;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
        if (op_r == OP_POP || op_r == OP_PEEK) pos_nxt = '0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Insert records its final position, remove reports the given index, search the found one; pop/peek report zero.
  logic [AddrW-1:0] fpos_r;
  logic [2:0] op0_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op0_r <= in_opcode; fpos_r <= in_index;
    end else if (op0_r == OP_INSERT && we) begin
      fpos_r <= wa;
    end else if (op0_r == OP_SEARCH && state_nxt == S_DONE && state_r == S_SCMP) begin
      fpos_r <= pos_nxt;
    end
  end

  logic [AddrW-1:0] rpt;
  always_comb begin
    unique case (op0_r)
      OP_INSERT, OP_REMOVE, OP_SEARCH: rpt = fpos_r;
      default: rpt = '0;
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_key         = (st_r == ST_OK) ? res_r[KeyW+PayW-1:PayW] : '0;
  assign out_payload     = (st_r == ST_OK) ? res_r[PayW-1:0] : '0;
  assign out_found_index = (st_r == ST_OK) ? rpt : '0;
  assign out_entry_count = cnt_r;

  `BMHQ_ASSERT(a_cnt_lim, clk, rst_n, cnt_r <= CntW'(Depth), "count above depth")
  `BMHQ_ASSERT(a_ov_once, clk, rst_n, out_valid |=> !out_valid, "double strobe")
  `BMHQ_ASSERT(a_idle_ov, clk, rst_n, out_valid |-> !busy, "strobe while busy")
endmodule
`default_nettype wire
